@@ hw/rtl/adpcm_nd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpcm_nd_pkg
// Shared types, constants and tables for the four-bit ADPCM nibble decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package adpcm_nd_pkg;

    localparam int PRED_W       = 12;
    localparam int STEP_W       = 6;
    localparam int SIZE_W       = 11;
    localparam int DELTA_W      = 12;
    localparam int MOVE_W       = 5;
    localparam int SAMPLE_W     = 16;
    localparam int NIBBLE_W     = 4;
    localparam int DIV_W        = 16;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int PRESCALER_BITS_DEF = 16;

    localparam logic [STEP_W-1:0] STEP_MAX = 6'd48;
    localparam logic signed [PRED_W-1:0] PRED_MIN = -12'sd2048;
    localparam logic signed [PRED_W-1:0] PRED_MAX = 12'sd2047;
    localparam logic [DIV_W-1:0] DIV_RESET = 16'd1;

    localparam logic [CFG_ADDR_W-3:0] REG_CLOCK_DIVIDER = 1'b0;

    typedef enum logic [1:0] {
        OP_NIBBLE = 2'd0,
        OP_RESET  = 2'd1,
        OP_TICK   = 2'd2,
        OP_SAMPLE = 2'd3
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [NIBBLE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       new_sample;
    } t_out_item;

    typedef struct packed {
        logic signed [PRED_W-1:0] pred;
        logic [STEP_W-1:0]        step;
    } t_dec_state;

    function automatic logic [SIZE_W-1:0] step_lookup(input logic [STEP_W-1:0] pos);
        logic [SIZE_W-1:0] s;
        case (pos)
            6'd0:  s = 11'd16;
            6'd1:  s = 11'd17;
            6'd2:  s = 11'd19;
            6'd3:  s = 11'd21;
            6'd4:  s = 11'd23;
            6'd5:  s = 11'd25;
            6'd6:  s = 11'd28;
            6'd7:  s = 11'd31;
            6'd8:  s = 11'd34;
            6'd9:  s = 11'd37;
            6'd10: s = 11'd41;
            6'd11: s = 11'd45;
            6'd12: s = 11'd50;
            6'd13: s = 11'd55;
            6'd14: s = 11'd60;
            6'd15: s = 11'd66;
            6'd16: s = 11'd73;
            6'd17: s = 11'd80;
            6'd18: s = 11'd88;
            6'd19: s = 11'd97;
            6'd20: s = 11'd107;
            6'd21: s = 11'd118;
            6'd22: s = 11'd130;
            6'd23: s = 11'd143;
            6'd24: s = 11'd157;
            6'd25: s = 11'd173;
            6'd26: s = 11'd185;
            6'd27: s = 11'd204;
            6'd28: s = 11'd224;
            6'd29: s = 11'd247;
            6'd30: s = 11'd272;
            6'd31: s = 11'd300;
            6'd32: s = 11'd330;
            6'd33: s = 11'd363;
            6'd34: s = 11'd399;
            6'd35: s = 11'd439;
            6'd36: s = 11'd483;
            6'd37: s = 11'd532;
            6'd38: s = 11'd585;
            6'd39: s = 11'd622;
            6'd40: s = 11'd684;
            6'd41: s = 11'd752;
            6'd42: s = 11'd828;
            6'd43: s = 11'd910;
            6'd44: s = 11'd1002;
            6'd45: s = 11'd1102;
            6'd46: s = 11'd1212;
            6'd47: s = 11'd1333;
            default: s = 11'd1466;
        endcase
        return s;
    endfunction

    function automatic logic signed [MOVE_W-1:0] step_move(input logic [2:0] code);
        logic signed [MOVE_W-1:0] m;
        case (code)
            3'd4:    m = 5'sd2;
            3'd5:    m = 5'sd4;
            3'd6:    m = 5'sd6;
            3'd7:    m = 5'sd8;
            default: m = -5'sd1;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/adpcm_nd_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpcm_nd_decode
// One ADPCM decode step: step size lookup, delta build, saturating predictor
// update and saturating step position update.
// ----------------------------------------------------------------------------
`default_nettype none

module adpcm_nd_decode (
    input  wire adpcm_nd_pkg::t_dec_state                  i_state,
    input  wire logic [adpcm_nd_pkg::NIBBLE_W-1:0]         i_nibble,
    output adpcm_nd_pkg::t_dec_state                       o_state
);
    import adpcm_nd_pkg::*;

    localparam int SUM_W = PRED_W + 2;
    localparam int POS_W = STEP_W + 1;

    logic [SIZE_W-1:0]         size;
    logic [DELTA_W-1:0]        delta;
    logic signed [SUM_W-1:0]   pred_ext;
    logic signed [SUM_W-1:0]   delta_ext;
    logic signed [SUM_W-1:0]   sum;
    logic signed [POS_W-1:0]   pos;

    always_comb begin
        size  = step_lookup(i_state.step);
        delta = DELTA_W'(size >> 3);
        if (i_nibble[2]) begin
            delta = delta + DELTA_W'(size);
        end
        if (i_nibble[1]) begin
            delta = delta + DELTA_W'(size >> 1);
        end
        if (i_nibble[0]) begin
            delta = delta + DELTA_W'(size >> 2);
        end

        pred_ext  = SUM_W'(i_state.pred);
        delta_ext = $signed({2'b00, delta});
        if (i_nibble[3]) begin
            sum = pred_ext - delta_ext;
        end else begin
            sum = pred_ext + delta_ext;
        end

        if (sum < SUM_W'(PRED_MIN)) begin
            o_state.pred = PRED_MIN;
        end else if (sum > SUM_W'(PRED_MAX)) begin
            o_state.pred = PRED_MAX;
        end else begin
            o_state.pred = sum[PRED_W-1:0];
        end

        pos = $signed({1'b0, i_state.step}) + POS_W'(step_move(i_nibble[2:0]));
        if (pos < 0) begin
            o_state.step = '0;
        end else if (pos > $signed({1'b0, STEP_MAX})) begin
            o_state.step = STEP_MAX;
        end else begin
            o_state.step = pos[STEP_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/adpcm_nibble_decoder_with_prescaler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpcm_nibble_decoder_with_prescaler
// Event driven four-bit ADPCM decoder with a master tick prescaler and an
// APB-style register for the clock divider.
// ----------------------------------------------------------------------------
// result path: an accepted request goes to the input reg, then its result to the result reg
// throughput: one request per cycle unless the output stalls; the decode step
//   fits between the input and result registers, with state written at the same edge
// reset: synchronous active low; clears state, divider returns to 1
// ----------------------------------------------------------------------------
`default_nettype none

module adpcm_nibble_decoder_with_prescaler #(
    parameter int PRESCALER_BITS = adpcm_nd_pkg::PRESCALER_BITS_DEF
) (
    input  wire                                           i_clk,
    input  wire                                           i_rst_n,

    input  wire                                           i_in_valid,
    output logic                                          o_in_stall,
    input  wire adpcm_nd_pkg::t_in_item                   i_in_data,

    output logic                                          o_out_valid,
    input  wire                                           i_out_stall,
    output adpcm_nd_pkg::t_out_item                       o_out_data,

    input  wire                                           i_psel,
    input  wire                                           i_penable,
    input  wire                                           i_pwrite,
    input  wire logic [adpcm_nd_pkg::CFG_ADDR_W-1:0]      i_paddr,
    input  wire logic [adpcm_nd_pkg::CFG_DATA_W-1:0]      i_pwdata,
    output logic [adpcm_nd_pkg::CFG_DATA_W-1:0]           o_prdata,
    output logic                                          o_pready
);
    import adpcm_nd_pkg::*;

    localparam int CMP_W = (PRESCALER_BITS > DIV_W) ? PRESCALER_BITS : DIV_W;

    logic                      r_in_valid;
    t_in_item                  r_in;
    logic                      r_out_valid;
    t_out_item                 r_out;
    logic [DIV_W-1:0]          r_divider;
    logic [NIBBLE_W-1:0]       r_nibble;
    logic                      r_reset_held;
    t_dec_state                r_dec;
    logic [PRESCALER_BITS-1:0] r_count;

    logic [NIBBLE_W-1:0]       n_nibble;
    logic                      n_reset_held;
    t_dec_state                n_dec;
    logic [PRESCALER_BITS-1:0] n_count;
    t_out_item                 n_out;

    t_dec_state                dec_next;
    logic [PRESCALER_BITS-1:0] count_inc;
    logic                      fire;
    logic                      out_free;
    logic                      proc;
    logic                      cfg_wr;

    adpcm_nd_decode u_decode (
        .i_state  (r_dec),
        .i_nibble (r_nibble),
        .o_state  (dec_next)
    );

    assign out_free    = !r_out_valid || !i_out_stall;
    assign proc        = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite &&
                      (i_paddr[CFG_ADDR_W-1:2] == REG_CLOCK_DIVIDER);
    always_comb begin
        o_prdata = '0;
        if (i_paddr[CFG_ADDR_W-1:2] == REG_CLOCK_DIVIDER) begin
            o_prdata = CFG_DATA_W'(r_divider);
        end
    end

    assign count_inc = r_count + 1'b1;

    always_comb begin
        n_nibble     = r_nibble;
        n_reset_held = r_reset_held;
        n_dec        = r_dec;
        n_count      = r_count;
        fire         = 1'b0;
        unique case (r_in.op)
            OP_NIBBLE: begin
                n_nibble = r_in.value;
            end
            OP_RESET: begin
                n_reset_held = r_in.value[0];
                if (r_in.value[0]) begin
                    n_dec   = '0;
                    n_count = '0;
                end
            end
            OP_TICK: begin
                if (CMP_W'(count_inc) >= CMP_W'(r_divider)) begin
                    n_count = '0;
                    fire    = 1'b1;
                end else begin
                    n_count = count_inc;
                end
            end
            OP_SAMPLE: begin
                fire = 1'b1;
            end
        endcase
        // predictor stays cleared while the reset line is held
        if (fire && !r_reset_held) begin
            n_dec = dec_next;
        end
        n_out.sample     = $signed({n_dec.pred, 4'b0000});
        n_out.new_sample = fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_divider    <= DIV_RESET;
            r_nibble     <= '0;
            r_reset_held <= 1'b0;
            r_dec        <= '0;
            r_count      <= '0;
        end else begin
            if (cfg_wr) begin
                r_divider <= i_pwdata[DIV_W-1:0];
            end
            if (!r_in_valid || proc) begin
                r_in_valid <= i_in_valid;
            end
            if (proc) begin
                r_nibble     <= n_nibble;
                r_reset_held <= n_reset_held;
                r_dec        <= n_dec;
                r_count      <= n_count;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_in_valid || proc) begin
            r_in <= i_in_data;
        end
        if (proc) begin
            r_out <= n_out;
        end
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dec.step <= STEP_MAX)
        else $error("step position beyond table");

    a_pred_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reset_held |-> (r_dec.pred == '0))
        else $error("predictor not cleared while reset line held");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall && r_in_valid))
        else $error("input stalled without a blocked result");

    a_proc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> o_out_valid)
        else $error("processed request produced no result");

endmodule

`default_nettype wire
